/* rtl/core/hdm_pkg.sv */
// ----------------------------------------------------------------------------
// hdm_pkg
// Shared types, register codes and arithmetic helpers for the mecanum drive
// mixer: deadband, saturation and the per-wheel slew step.
// ----------------------------------------------------------------------------
package hdm_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int DB_W       = 7;
	localparam int RATE_W     = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADBAND = 1'b0,
		CFG_ACCEL    = 1'b1
	} cfg_reg_t;

	localparam logic [DB_W-1:0]   DB_RESET   = 7'd15;
	localparam logic [RATE_W-1:0] RATE_RESET = 8'd115;

	typedef logic signed [7:0] drive_t;

	// one classified request: four wheel targets plus the link flag
	typedef struct packed {
		logic   link_valid;
		drive_t fl;
		drive_t fr;
		drive_t bl;
		drive_t br;
	} mix_t;

	function automatic drive_t deadband(input drive_t raw, input logic [DB_W-1:0] thr);
		logic [7:0] mag;
		drive_t     res;
		// -128 gives magnitude 128, which passes any threshold
		mag = raw[7] ? (~raw + 8'd1) : raw;
		if (mag < {1'b0, thr}) begin
			res = '0;
		end else if (raw == -8'sd128) begin
			res = -8'sd127;
		end else begin
			res = raw;
		end
		return res;
	endfunction

	function automatic drive_t sat8(input logic signed [9:0] v);
		drive_t res;
		if (v < -10'sd128) begin
			res = -8'sd128;
		end else if (v > 10'sd127) begin
			res = 8'sd127;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	// move cur toward tgt by diff*rate/256 (toward zero), at least one step
	function automatic drive_t slew(input drive_t cur, input drive_t tgt,
			input logic [RATE_W-1:0] rate);
		logic signed [8:0] diff;
		logic [8:0]        mag;
		logic [16:0]       prod;
		logic [8:0]        chg;
		logic signed [9:0] sum;
		diff = $signed({tgt[7], tgt}) - $signed({cur[7], cur});
		mag  = diff[8] ? (~diff + 9'd1) : diff;
		prod = mag * rate;
		chg  = prod[16:8];
		if (chg == 9'd0 && diff != 9'sd0) begin
			chg = 9'd1;
		end
		if (diff[8]) begin
			sum = $signed({{2{cur[7]}}, cur}) - $signed({1'b0, chg});
		end else begin
			sum = $signed({{2{cur[7]}}, cur}) + $signed({1'b0, chg});
		end
		return sum[7:0];
	endfunction

endpackage

/* rtl/core/hdm_ifs.sv */
// ----------------------------------------------------------------------------
// hdm channel interfaces
// Joystick request channel and wheel drive result channel, valid/ready.
// ----------------------------------------------------------------------------
interface hdm_cmd_if;
	import hdm_pkg::*;

	logic   valid;
	logic   ready;
	drive_t joy_left_x;
	drive_t joy_left_y;
	drive_t joy_right_x;
	logic   link_valid;

	modport source (output valid, output joy_left_x, output joy_left_y,
		output joy_right_x, output link_valid, input ready);
	modport sink (input valid, input joy_left_x, input joy_left_y,
		input joy_right_x, input link_valid, output ready);
endinterface

interface hdm_drive_if;
	import hdm_pkg::*;

	logic   valid;
	logic   ready;
	drive_t front_left_drive;
	drive_t front_right_drive;
	drive_t back_left_drive;
	drive_t back_right_drive;

	modport source (output valid, output front_left_drive, output front_right_drive,
		output back_left_drive, output back_right_drive, input ready);
	modport sink (input valid, input front_left_drive, input front_right_drive,
		input back_left_drive, input back_right_drive, output ready);
endinterface

/* rtl/core/hdm_front.sv */
// ----------------------------------------------------------------------------
// hdm_front
// Takes joystick requests, applies the deadband and mixes the three axes
// into four saturated wheel targets for the queue.
// ----------------------------------------------------------------------------
module hdm_front (
	hdm_cmd_if.sink                   cmd,
	input  logic [hdm_pkg::DB_W-1:0]  db_thr,
	output logic                      push_valid,
	output hdm_pkg::mix_t             push_data,
	input  logic                      push_ready
);
	import hdm_pkg::*;

	drive_t            strafe;
	drive_t            fwd;
	drive_t            yaw;
	logic signed [9:0] s10;
	logic signed [9:0] f10;
	logic signed [9:0] y10;

	always_comb begin
		strafe = deadband(cmd.joy_left_x, db_thr);
		fwd    = -deadband(cmd.joy_left_y, db_thr);
		yaw    = deadband(cmd.joy_right_x, db_thr);
		s10    = {{2{strafe[7]}}, strafe};
		f10    = {{2{fwd[7]}}, fwd};
		y10    = {{2{yaw[7]}}, yaw};

		push_data.link_valid = cmd.link_valid;
		push_data.fl = sat8(y10 - f10 + s10);
		push_data.fr = sat8(y10 + f10 + s10);
		push_data.bl = sat8(y10 - f10 - s10);
		push_data.br = sat8(y10 + f10 - s10);
	end

	assign push_valid = cmd.valid;
	assign cmd.ready  = push_ready;

endmodule

/* rtl/core/hdm_queue.sv */
// ----------------------------------------------------------------------------
// hdm_queue
// Small FIFO between the mixer front and the slew back end.
// ----------------------------------------------------------------------------
module hdm_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  hdm_pkg::mix_t push_data,
	output logic          push_ready,
	output logic          pop_valid,
	output hdm_pkg::mix_t pop_data,
	input  logic          pop_ready
);
	import hdm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mix_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/hdm_back.sv */
// ----------------------------------------------------------------------------
// hdm_back
// Slew-limits the four kept wheel speeds toward their targets and holds the
// result in the output register; link down outputs zero, speeds hold.
// ----------------------------------------------------------------------------
module hdm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hdm_pkg::RATE_W-1:0]  rate,
	input  logic                        pop_valid,
	input  hdm_pkg::mix_t               pop_data,
	output logic                        pop_ready,
	hdm_drive_if.source                 drive
);
	import hdm_pkg::*;

	drive_t speed_fl_q;
	drive_t speed_fr_q;
	drive_t speed_bl_q;
	drive_t speed_br_q;
	drive_t next_fl;
	drive_t next_fr;
	drive_t next_bl;
	drive_t next_br;
	logic   out_valid_q;
	drive_t out_fl_q;
	drive_t out_fr_q;
	drive_t out_bl_q;
	drive_t out_br_q;
	logic   pop;

	assign pop_ready = !out_valid_q || drive.ready;
	assign pop       = pop_valid && pop_ready;

	// four independent slew lanes
	always_comb begin
		next_fl = slew(speed_fl_q, pop_data.fl, rate);
		next_fr = slew(speed_fr_q, pop_data.fr, rate);
		next_bl = slew(speed_bl_q, pop_data.bl, rate);
		next_br = slew(speed_br_q, pop_data.br, rate);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_fl_q  <= '0;
			speed_fr_q  <= '0;
			speed_bl_q  <= '0;
			speed_br_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
			// link down: speeds hold
			if (pop && pop_data.link_valid) begin
				speed_fl_q <= next_fl;
				speed_fr_q <= next_fr;
				speed_bl_q <= next_bl;
				speed_br_q <= next_br;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_data.link_valid) begin
				out_fl_q <= next_fl;
				out_fr_q <= next_fr;
				out_bl_q <= next_bl;
				out_br_q <= next_br;
			end else begin
				out_fl_q <= '0;
				out_fr_q <= '0;
				out_bl_q <= '0;
				out_br_q <= '0;
			end
		end
	end

	assign drive.valid             = out_valid_q;
	assign drive.front_left_drive  = out_fl_q;
	assign drive.front_right_drive = out_fr_q;
	assign drive.back_left_drive   = out_bl_q;
	assign drive.back_right_drive  = out_br_q;

endmodule

/* rtl/core/holonomic_drive_mixer_with_slew.sv */
// ----------------------------------------------------------------------------
// holonomic_drive_mixer_with_slew
// Path: an accepted request goes into the queue, then into the output register.
// Throughput: one request per cycle while the drive side takes results,
// bounded by the loop through the four speed registers and their slew lanes.
// Reset: speeds cleared to zero, deadband 15, rate 115, queue and output empty.
// ----------------------------------------------------------------------------
module holonomic_drive_mixer_with_slew #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	hdm_cmd_if.sink                           cmd,
	hdm_drive_if.source                       drive,
	input  logic                              wr_en,
	input  hdm_pkg::cfg_reg_t                 wr_index,
	input  logic [hdm_pkg::CFG_DATA_W-1:0]    wr_data
);
	import hdm_pkg::*;

	logic [DB_W-1:0]   db_thr_q;
	logic [RATE_W-1:0] rate_q;
	logic              push_valid;
	mix_t              push_data;
	logic              push_ready;
	logic              pop_valid;
	mix_t              pop_data;
	logic              pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_thr_q <= DB_RESET;
			rate_q   <= RATE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DEADBAND: db_thr_q <= wr_data[DB_W-1:0];
				CFG_ACCEL:    rate_q   <= wr_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	hdm_front u_front (
		.cmd        (cmd),
		.db_thr     (db_thr_q),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	hdm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	hdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rate      (rate_q),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.drive     (drive)
	);

endmodule

/* rtl/core/hdm_checker.sv */
// ----------------------------------------------------------------------------
// hdm_checker
// Port-level checks on the request and drive channels of the mixer.
// ----------------------------------------------------------------------------
module hdm_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic drive_valid,
	input logic drive_ready
);

	// a held result stays offered until taken
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> drive_valid)
		else $error("drive result dropped while stalled");

	// the queue only fills up behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> drive_valid)
		else $error("request side stalled with no pending result");

	// a new result always follows an accepted request, which goes first into the
	// queue and then into the output register
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result raised without a request");

endmodule

bind holonomic_drive_mixer_with_slew hdm_checker u_hdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.drive_valid (drive.valid),
	.drive_ready (drive.ready)
);
